// File: design/image_rotate_flip_crop_engine_core_assert.svh
// Assertion macros for the image rotate/flip/crop engine.
// Used by the controller; needs nothing but a clock and a reset name.
`ifndef IMAGE_ROTATE_FLIP_CROP_ENGINE_CORE_ASSERT_SVH
`define IMAGE_ROTATE_FLIP_CROP_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication.
`define IRFC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IRFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/irfc_pkg.sv
// Package for the image rotate/flip/crop engine.
// Word types, function codes, controller states and control structs.
package irfc_pkg;

  localparam int DIM_BITS   = 7;
  localparam int MAX_DIM    = 1 << DIM_BITS;
  localparam int ADDR_BITS  = 2 * DIM_BITS;
  localparam int DEPTH      = 1 << ADDR_BITS;
  localparam int PIXEL_BITS = 32;

  typedef enum logic [2:0] {
    FN_WRITE  = 3'd0,
    FN_ROTATE = 3'd1,
    FN_VFLIP  = 3'd2,
    FN_HFLIP  = 3'd3,
    FN_CROP   = 3'd4,
    FN_READ   = 3'd5
  } func_t;

  typedef enum logic [0:0] {
    CFG_START_ROWS = 1'b0,
    CFG_START_COLS = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_COPY_END,
    ST_MAP,
    ST_MAP_END,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0]        func;
    logic [6:0]        pixel_row;
    logic [6:0]        pixel_col;
    logic signed [31:0] pixel_in;
    logic              turn_left;
    logic signed [7:0] turn_count;
    logic [7:0]        crop_left;
    logic [7:0]        crop_right;
    logic [7:0]        crop_top;
    logic [7:0]        crop_bottom;
  } cmd_word_t;

  typedef struct packed {
    logic signed [31:0] pixel_out;
    logic [7:0]         rows_now;
    logic [7:0]         cols_now;
    logic               status;
  } res_word_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic copy_step;
    logic map_start;
    logic map_step;
    logic finish;
    logic cfg_write;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_sweep;
    logic copy_last;
    logic map_last;
  } dp_status_t;

  function automatic logic [7:0] clamp_dim(logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (v == 8'd0) r = 8'd1;
    else if (v > 8'(MAX_DIM)) r = 8'(MAX_DIM);
    return r;
  endfunction

endpackage

// File: design/irfc_datapath.sv
// Datapath: frame and scratch memories, sweep counters, address mapping,
// dimension registers and result register. Depends on irfc_pkg.
module irfc_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  irfc_pkg::cmd_word_t  cmd,
  input  irfc_pkg::ctl_cmd_t   ctl,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_data,
  output irfc_pkg::dp_status_t sts,
  output irfc_pkg::res_word_t  res
);

  localparam int DB = irfc_pkg::DIM_BITS;
  localparam int AB = irfc_pkg::ADDR_BITS;
  localparam int PB = irfc_pkg::PIXEL_BITS;

  logic [PB-1:0] frame [irfc_pkg::DEPTH];
  logic [PB-1:0] scratch [irfc_pkg::DEPTH];

  irfc_pkg::cmd_word_t c;
  logic [7:0]    cur_rows, cur_cols;
  logic [DB-1:0] ri, ci;
  logic          copy_wr_v, map_wr_v, map_zero;
  logic [AB-1:0] copy_wr_addr, map_wr_addr;
  logic [PB-1:0] frame_rdata, scr_rdata;

  logic [1:0]    q;
  logic          pixel_ok, crop_ok, odd_turn;
  logic [7:0]    ie, je, sr, sc, map_r, map_c, lim_c, crop_h, crop_w;
  logic [7:0]    rows_new, cols_new;
  logic [AB-1:0] frame_raddr, src_addr;
  irfc_pkg::func_t fn;

  always_comb begin
    fn = irfc_pkg::func_t'(c.func);
    q = c.turn_left ? 2'(-c.turn_count[1:0]) : c.turn_count[1:0];
    odd_turn = (fn == irfc_pkg::FN_ROTATE) && q[0];
    pixel_ok = ({1'b0, c.pixel_row} < cur_rows) && ({1'b0, c.pixel_col} < cur_cols);
    crop_ok = (c.crop_left >= 8'd1) && (c.crop_left <= c.crop_right) &&
              (c.crop_right <= cur_cols) && (c.crop_top >= 8'd1) &&
              (c.crop_top <= c.crop_bottom) && (c.crop_bottom <= cur_rows);
    crop_h = c.crop_bottom - c.crop_top + 8'd1;
    crop_w = c.crop_right - c.crop_left + 8'd1;
    ie = {1'b0, ri};
    je = {1'b0, ci};
    map_r = odd_turn ? cur_cols : cur_rows;
    map_c = odd_turn ? cur_rows : cur_cols;
    lim_c = ctl.map_step ? map_c : cur_cols;
    sr = ie;
    sc = je;
    case (fn)
      irfc_pkg::FN_ROTATE: begin
        case (q)
          2'd1: begin
            sr = cur_rows - 8'd1 - je;
            sc = ie;
          end
          2'd2: begin
            sr = cur_rows - 8'd1 - ie;
            sc = cur_cols - 8'd1 - je;
          end
          default: begin
            sr = je;
            sc = cur_cols - 8'd1 - ie;
          end
        endcase
      end
      irfc_pkg::FN_VFLIP: sr = cur_rows - 8'd1 - ie;
      irfc_pkg::FN_HFLIP: sc = cur_cols - 8'd1 - je;
      irfc_pkg::FN_CROP: begin
        sr = c.crop_top - 8'd1 + ie;
        sc = c.crop_left - 8'd1 + je;
      end
      default: ;
    endcase
    src_addr = {sr[DB-1:0], sc[DB-1:0]};
    frame_raddr = ctl.copy_step ? {ri, ci} : {c.pixel_row, c.pixel_col};
    sts.need_sweep = ((fn == irfc_pkg::FN_ROTATE) && (q != 2'd0)) ||
                     (fn == irfc_pkg::FN_VFLIP) || (fn == irfc_pkg::FN_HFLIP) ||
                     ((fn == irfc_pkg::FN_CROP) && crop_ok);
    sts.copy_last = (ie == cur_rows - 8'd1) && (je == cur_cols - 8'd1);
    sts.map_last = (ie == map_r - 8'd1) && (je == map_c - 8'd1);
    rows_new = cur_rows;
    cols_new = cur_cols;
    if (odd_turn) begin
      rows_new = cur_cols;
      cols_new = cur_rows;
    end else if ((fn == irfc_pkg::FN_CROP) && crop_ok) begin
      rows_new = crop_h;
      cols_new = crop_w;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) c <= cmd;
    if (ctl.load || ctl.map_start) begin
      ri <= '0;
      ci <= '0;
    end else if (ctl.copy_step || ctl.map_step) begin
      if (je == lim_c - 8'd1) begin
        ci <= '0;
        ri <= ri + 1'b1;
      end else begin
        ci <= ci + 1'b1;
      end
    end
    copy_wr_addr <= {ri, ci};
    map_wr_addr <= {ri, ci};
    map_zero <= (fn == irfc_pkg::FN_CROP) && ((ie >= crop_h) || (je >= crop_w));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      copy_wr_v <= 1'b0;
      map_wr_v <= 1'b0;
      cur_rows <= 8'd1;
      cur_cols <= 8'd1;
    end else begin
      copy_wr_v <= ctl.copy_step;
      map_wr_v <= ctl.map_step;
      if (ctl.cfg_write) begin
        if (irfc_pkg::cfg_reg_t'(cfg_index) == irfc_pkg::CFG_START_ROWS)
          cur_rows <= irfc_pkg::clamp_dim(cfg_data);
        else
          cur_cols <= irfc_pkg::clamp_dim(cfg_data);
      end else if (ctl.finish) begin
        cur_rows <= rows_new;
        cur_cols <= cols_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (map_wr_v)
      frame[map_wr_addr] <= map_zero ? '0 : scr_rdata;
    else if (ctl.exec && (fn == irfc_pkg::FN_WRITE) && pixel_ok)
      frame[{c.pixel_row, c.pixel_col}] <= c.pixel_in[PB-1:0];
    frame_rdata <= frame[frame_raddr];
  end

  always_ff @(posedge clk) begin
    if (copy_wr_v) scratch[copy_wr_addr] <= frame_rdata;
    scr_rdata <= scratch[src_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      res.pixel_out <= ((fn == irfc_pkg::FN_READ) && pixel_ok) ? frame_rdata : '0;
      res.rows_now <= rows_new;
      res.cols_now <= cols_new;
      res.status <= (((fn == irfc_pkg::FN_WRITE) || (fn == irfc_pkg::FN_READ)) && !pixel_ok)
                    || ((fn == irfc_pkg::FN_CROP) && !crop_ok);
    end
  end

endmodule

// File: design/irfc_controller.sv
// Controller: command sequencing state machine and result valid.
// Depends on irfc_pkg and the assertion macro header.
`include "image_rotate_flip_crop_engine_core_assert.svh"

module irfc_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  output logic                 res_valid,
  input  logic                 res_stall,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  irfc_pkg::dp_status_t sts,
  output irfc_pkg::ctl_cmd_t   ctl
);

  irfc_pkg::state_t state, state_next;
  logic accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= irfc_pkg::ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.finish) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    cmd_stall = !((state == irfc_pkg::ST_IDLE) && (!res_valid || !res_stall));
    accept = cmd_valid && !cmd_stall;
    cfg_ready = (state == irfc_pkg::ST_IDLE);
    ctl.cfg_write = cfg_valid && cfg_ready;
    case (state)
      irfc_pkg::ST_IDLE: begin
        if (accept) begin
          ctl.load = 1'b1;
          state_next = irfc_pkg::ST_EXEC;
        end
      end
      irfc_pkg::ST_EXEC: begin
        ctl.exec = 1'b1;
        state_next = sts.need_sweep ? irfc_pkg::ST_COPY : irfc_pkg::ST_FINISH;
      end
      irfc_pkg::ST_COPY: begin
        ctl.copy_step = 1'b1;
        if (sts.copy_last) state_next = irfc_pkg::ST_COPY_END;
      end
      irfc_pkg::ST_COPY_END: begin
        ctl.map_start = 1'b1;
        state_next = irfc_pkg::ST_MAP;
      end
      irfc_pkg::ST_MAP: begin
        ctl.map_step = 1'b1;
        if (sts.map_last) state_next = irfc_pkg::ST_MAP_END;
      end
      irfc_pkg::ST_MAP_END: state_next = irfc_pkg::ST_FINISH;
      irfc_pkg::ST_FINISH: begin
        ctl.finish = 1'b1;
        state_next = irfc_pkg::ST_IDLE;
      end
      default: state_next = irfc_pkg::ST_IDLE;
    endcase
  end

  `IRFC_ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == irfc_pkg::ST_EXEC, "accept must enter exec")
  `IRFC_ASSERT_NEXT(a_finish_valid, clk, rst, state == irfc_pkg::ST_FINISH, res_valid, "finish must raise valid")
  `IRFC_ASSERT_SAME(a_busy_empty, clk, rst, state != irfc_pkg::ST_IDLE, !res_valid, "result pending while busy")
  `IRFC_ASSERT_NEXT(a_copy_end, clk, rst, (state == irfc_pkg::ST_COPY) && sts.copy_last, state == irfc_pkg::ST_COPY_END, "copy sweep overran")

endmodule

// File: design/image_rotate_flip_crop_engine_core.sv
// Image rotate/flip/crop engine, top level. Joins controller and datapath.
// Depends on irfc_pkg, irfc_controller and irfc_datapath.
// One command word at a time. Pixel write, pixel read, zero-turn rotate,
// rejected crop and unused codes pass only through the exec and finish
// states to the result. Rotate, flip and crop copy the current rows*cols
// frame into a scratch memory and then map it back, one pixel per cycle
// through 16384-word memories with a separate write and read port.
// Configuration writes are taken only while no command is in work and
// reload the current row or column count (0 reads as 1, >128 as 128).
module image_rotate_flip_crop_engine_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  irfc_pkg::cmd_word_t cmd,
  output logic                res_valid,
  input  logic                res_stall,
  output irfc_pkg::res_word_t res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data
);

  irfc_pkg::ctl_cmd_t   ctl;
  irfc_pkg::dp_status_t sts;

  irfc_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  irfc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .res       (res)
  );

endmodule
